FILE: rtl/core/asp_pkg.sv
`default_nettype none

package asp_pkg;

   // Archive layout
   localparam int HEADER_BYTES      = 60;
   localparam int SIZE_DIGITS       = 10;
   localparam int NAME_BYTES        = 16;
   localparam int MEMBER_COUNT_BITS = 16;

   localparam int SIZE_START = 48;
   localparam int SIZE_END   = SIZE_START + SIZE_DIGITS;
   localparam int TRAILER_A  = HEADER_BYTES - 2;
   localparam int TRAILER_B  = HEADER_BYTES - 1;

   localparam int POS_W  = 6;
   localparam int SIZE_W = 34;
   localparam int CNT_W  = 16;

   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   // Member counter saturates at the smaller of the configured width and the port width
   localparam logic [63:0] CNT_LIMIT_WIDE = (64'd1 << MEMBER_COUNT_BITS) - 64'd1;
   localparam logic [CNT_W-1:0] CNT_LIMIT =
      (MEMBER_COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_LIMIT_WIDE[CNT_W-1:0];

   localparam logic [7:0] AR_MAGIC [0:7] = '{
      8'h21, 8'h3C, 8'h61, 8'h72, 8'h63, 8'h68, 8'h3E, 8'h0A
   };
   localparam logic [7:0] CHR_TRAIL_A = 8'h60;
   localparam logic [7:0] CHR_TRAIL_B = 8'h0A;
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_NINE    = 8'h39;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_TAB     = 8'h09;
   localparam logic [7:0] CHR_CR      = 8'h0D;

   // Byte roles
   localparam logic [2:0] ROLE_MAGIC   = 3'd0;
   localparam logic [2:0] ROLE_NAME    = 3'd1;
   localparam logic [2:0] ROLE_SIZE    = 3'd2;
   localparam logic [2:0] ROLE_OTHER   = 3'd3;
   localparam logic [2:0] ROLE_DATA    = 3'd4;
   localparam logic [2:0] ROLE_PAD     = 3'd5;
   localparam logic [2:0] ROLE_IGNORED = 3'd6;

   // Parse status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_MAGIC   = 3'd1;
   localparam logic [2:0] ST_TRAILER = 3'd2;
   localparam logic [2:0] ST_SIZE    = 3'd3;
   localparam logic [2:0] ST_TRUNC   = 3'd4;

   // Size field scan
   typedef enum logic [1:0] {
      SS_LEAD   = 2'd0,
      SS_DIGITS = 2'd1,
      SS_TRAIL  = 2'd2,
      SS_BAD    = 2'd3
   } size_sub_type;

   typedef struct packed {
      size_sub_type      sub;
      logic [SIZE_W-1:0] acc;
   } size_scan_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } asp_req_type;

   typedef struct packed {
      logic [7:0]       byte_out;
      logic [2:0]       byte_role;
      logic [CNT_W-1:0] member_number;
      logic             member_done;
      logic [2:0]       parse_status;
      logic [CNT_W-1:0] members_complete;
      logic             final_flag;
   } asp_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/asp_size_scan.sv
`default_nettype none

module asp_size_scan (
   input  asp_pkg::size_scan_type cur,
   input  logic [7:0]             data_byte,
   output asp_pkg::size_scan_type nxt
);
   import asp_pkg::*;

   logic                is_digit;
   logic                is_ws;
   logic [3:0]          digit;
   logic [SIZE_W+3:0]   acc_ext;
   logic [SIZE_W+3:0]   acc_x10;
   logic                ovf;

   // Character classes
   assign is_digit = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
   assign is_ws    = (data_byte == CHR_SPACE) ||
                     ((data_byte >= CHR_TAB) && (data_byte <= CHR_CR));
   assign digit    = 4'(data_byte - CHR_ZERO);

   // acc * 10 + digit; beyond the 34-bit range means a bad size
   assign acc_ext = {4'b0, cur.acc};
   assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + {{SIZE_W{1'b0}}, digit};
   assign ovf     = acc_x10 > {4'b0, SIZE_MAX};

   always_comb begin
      nxt = cur;
      unique case (cur.sub) inside
         SS_LEAD, SS_DIGITS: begin
            if (is_digit) begin
               if (ovf) begin
                  nxt.sub = SS_BAD;
               end else begin
                  nxt.acc = acc_x10[SIZE_W-1:0];
                  nxt.sub = SS_DIGITS;
               end
            end else if (is_ws) begin
               if (cur.sub == SS_DIGITS) nxt.sub = SS_TRAIL;
            end else begin
               nxt.sub = SS_BAD;
            end
         end
         SS_TRAIL: begin
            if (!is_ws) nxt.sub = SS_BAD;
         end
         default: begin
            nxt.sub = SS_BAD;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/asp_parse_engine.sv
`default_nettype none

module asp_parse_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  asp_pkg::asp_req_type req,
   output asp_pkg::asp_rsp_type rsp
);
   import asp_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC  = 3'd0,
      PH_HEADER = 3'd1,
      PH_DATA   = 3'd2,
      PH_PAD    = 3'd3,
      PH_STOP   = 3'd4
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   size_scan_type     size_ff, size_in;
   size_scan_type     size_step;
   logic              trl_ok_ff, trl_ok_in;
   logic [SIZE_W-1:0] remain_ff, remain_in;
   logic              pad_ff, pad_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        stop_ff, stop_in;

   logic [2:0]        hdr_role;
   logic [2:0]        role;
   logic [2:0]        status;
   logic              done;
   logic              start_hdr;
   logic              bump;

   asp_size_scan u_size_scan (
      .cur       (size_ff),
      .data_byte (req.data_byte),
      .nxt       (size_step)
   );

   // Role of a header byte by its position
   always_comb begin
      if (int'(pos_ff) < NAME_BYTES) begin
         hdr_role = ROLE_NAME;
      end else if (int'(pos_ff) >= SIZE_START && int'(pos_ff) < SIZE_END &&
                   int'(pos_ff) < TRAILER_A) begin
         hdr_role = ROLE_SIZE;
      end else begin
         hdr_role = ROLE_OTHER;
      end
   end

   // Next state and tagged result for the byte in hand
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      size_in   = size_ff;
      trl_ok_in = trl_ok_ff;
      remain_in = remain_ff;
      pad_in    = pad_ff;
      count_in  = count_ff;
      stop_in   = stop_ff;
      role      = ROLE_IGNORED;
      status    = ST_OK;
      done      = 1'b0;
      start_hdr = 1'b0;
      bump      = 1'b0;

      unique case (phase_ff)
         PH_MAGIC: begin
            role = ROLE_MAGIC;
            if (req.data_byte != AR_MAGIC[pos_ff[2:0]]) begin
               status = ST_MAGIC;
            end else if (pos_ff >= POS_W'(7)) begin
               start_hdr = 1'b1;
            end else begin
               pos_in = pos_ff + POS_W'(1);
               if (req.stream_end) status = ST_MAGIC;
            end
         end
         PH_HEADER: begin
            role = hdr_role;
            if (hdr_role == ROLE_SIZE) size_in = size_step;
            if (int'(pos_ff) == TRAILER_A) trl_ok_in = (req.data_byte == CHR_TRAIL_A);
            if (int'(pos_ff) >= TRAILER_B) begin
               if (!(trl_ok_ff && req.data_byte == CHR_TRAIL_B)) begin
                  status = ST_TRAILER;
               end else if (size_ff.sub == SS_LEAD || size_ff.sub == SS_BAD) begin
                  status = ST_SIZE;
               end else if (size_ff.acc == '0) begin
                  // empty member ends on its last header byte
                  done      = 1'b1;
                  bump      = 1'b1;
                  start_hdr = 1'b1;
               end else begin
                  remain_in = size_ff.acc;
                  pad_in    = size_ff.acc[0];
                  phase_in  = PH_DATA;
                  if (req.stream_end) status = ST_TRUNC;
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         PH_DATA: begin
            role = ROLE_DATA;
            if (remain_ff <= SIZE_W'(1)) begin
               remain_in = '0;
               done      = 1'b1;
               bump      = 1'b1;
               if (pad_ff) phase_in = PH_PAD;
               else start_hdr = 1'b1;
            end else begin
               remain_in = remain_ff - SIZE_W'(1);
               if (req.stream_end) status = ST_TRUNC;
            end
         end
         PH_PAD: begin
            // pad value is not checked
            role      = ROLE_PAD;
            start_hdr = 1'b1;
         end
         default: begin
            status = stop_ff;
         end
      endcase

      if (bump && count_ff != CNT_LIMIT) count_in = count_ff + CNT_W'(1);

      if (start_hdr) begin
         phase_in  = PH_HEADER;
         pos_in    = '0;
         size_in   = '{sub: SS_LEAD, acc: '0};
         trl_ok_in = 1'b0;
      end

      // First error stops the parse
      if (status != ST_OK && phase_ff != PH_STOP) begin
         stop_in  = status;
         phase_in = PH_STOP;
      end

      rsp.byte_out         = req.data_byte;
      rsp.byte_role        = role;
      rsp.member_number    = count_ff;
      rsp.member_done      = done;
      rsp.parse_status     = status;
      rsp.members_complete = count_in;
      rsp.final_flag       = req.stream_end;

      // Stream end: next byte opens a new archive
      if (req.stream_end) begin
         phase_in  = PH_MAGIC;
         pos_in    = '0;
         size_in   = '{sub: SS_LEAD, acc: '0};
         trl_ok_in = 1'b0;
         remain_in = '0;
         pad_in    = 1'b0;
         count_in  = '0;
         stop_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         pos_ff    <= '0;
         size_ff   <= '{sub: SS_LEAD, acc: '0};
         trl_ok_ff <= 1'b0;
         remain_ff <= '0;
         pad_ff    <= 1'b0;
         count_ff  <= '0;
         stop_ff   <= ST_OK;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         size_ff   <= size_in;
         trl_ok_ff <= trl_ok_in;
         remain_ff <= remain_in;
         pad_ff    <= pad_in;
         count_ff  <= count_in;
         stop_ff   <= stop_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/ar_archive_stream_parser.sv
//  channel | ports                                  | direction | carries
//  --------+----------------------------------------+-----------+--------------------------
//  req     | req_valid, req_ready, req_data         | in        | archive byte, stream end
//  rsp     | rsp_valid, rsp_ready, rsp_data         | out       | tagged byte, status
//
//  One byte per cycle sustained while rsp_ready stays high; a byte's result reaches rsp
//  through the input register, then the result register.
//  The parse state advances as a byte moves from the input register into the result
//  register, so rsp stalls hold the input register and then req_ready drops.
//  Synchronous active-high reset clears the parse state and both valid flags; no
//  clearing pass is needed.
`default_nettype none

module ar_archive_stream_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  asp_pkg::asp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output asp_pkg::asp_rsp_type rsp_data
);
   import asp_pkg::*;

   logic        in_valid_ff, in_valid_in;
   asp_req_type req_ff, req_in;
   logic        out_valid_ff, out_valid_in;
   asp_rsp_type rsp_ff, rsp_in;
   asp_rsp_type rsp_next;
   logic        advance;

   // Byte moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   asp_parse_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .rsp   (rsp_next)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      req_in       = req_ff;
      out_valid_in = out_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         req_in      = req_data;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         rsp_in       = rsp_next;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/asp_checker.sv
`default_nettype none

module asp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input asp_pkg::asp_rsp_type rsp_data
);
   import asp_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Ignored bytes only follow an error and never close a member
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_role == ROLE_IGNORED |->
         rsp_data.parse_status != ST_OK && !rsp_data.member_done)
      else $error("ignored byte without error or with member end");

   // A member end bumps the count unless saturated
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.member_done && rsp_data.member_number != CNT_LIMIT |->
         rsp_data.members_complete == rsp_data.member_number + CNT_W'(1))
      else $error("member end without count step");

   // Without a member end the count stays
   a_no_done_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.member_done |->
         rsp_data.members_complete == rsp_data.member_number)
      else $error("count moved without member end");

endmodule

bind ar_archive_stream_parser asp_checker u_asp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
